### design/lrlm_pkg.sv
// Shared types and constants of the loop rate load monitor.
package lrlm_pkg;

	localparam int unsigned CFG_IDX_BITS = 1;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEADLINE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 1'd1;
	localparam logic [CFG_DATA_BITS-1:0] INTERVAL_RESET = 16'd1000;
	localparam logic [31:0] US_PER_MS = 32'd1000;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUO_BITS = 7;

	typedef struct packed {
		logic        opcode;
		logic [31:0] now_us;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] best_count;
		logic [31:0] worst_count;
		logic [31:0] recent_count;
		logic        window_valid;
		logic        window_closed;
		logic [6:0]  load_percent;
		logic [31:0] worst_delay_us;
		logic [31:0] gap_min_us;
		logic [31:0] gap_max_us;
		logic [31:0] deadlines_missed;
	} out_item_t;

	typedef enum logic {
		OP_EVENT = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		logic        is_clear;
		logic [31:0] us;
		logic [31:0] ms;
	} cmd_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0] wdata;
	} cfg_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_MUL,
		S_DIV,
		S_OUT
	} back_state_t;

endpackage

### design/lrlm_front.sv
// Input stage: takes items and classifies them into commands for the queue.
module lrlm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lrlm_pkg::in_item_t item,
	output logic               cmd_valid,
	output lrlm_pkg::cmd_t     cmd,
	input  logic               cmd_full
);

	logic           valid_s1;
	lrlm_pkg::cmd_t cmd_s1;
	logic           take;

	assign full      = valid_s1 && cmd_full;
	assign take      = push && !full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.is_clear <= (lrlm_pkg::op_t'(item.opcode) == lrlm_pkg::OP_CLEAR);
			cmd_s1.us       <= item.now_us;
			cmd_s1.ms       <= item.now_ms;
		end
	end

endmodule

### design/lrlm_queue.sv
// Short command queue between the front and back parts.
module lrlm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  lrlm_pkg::cmd_t wr_cmd,
	output logic           q_full,
	input  logic           rd_pop,
	output logic           q_empty,
	output lrlm_pkg::cmd_t rd_cmd
);

	localparam int unsigned PTR_BITS = $clog2(lrlm_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_BITS = $clog2(lrlm_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(lrlm_pkg::QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(lrlm_pkg::QUEUE_DEPTH - 1);

	lrlm_pkg::cmd_t        mem_q [lrlm_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = (cnt_q == DEPTH_CNT);
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_valid && !q_full;
	assign do_rd   = rd_pop && !q_empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

### design/lrlm_back.sv
// Statistics engine: gap and window tracking, serial load divide, result register.
module lrlm_back #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrlm_pkg::cfg_wr_t   cfg,
	input  logic                q_empty,
	input  lrlm_pkg::cmd_t      q_cmd,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output lrlm_pkg::out_item_t result
);

	localparam int unsigned NUM_BITS = COUNT_BITS + lrlm_pkg::QUO_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [2:0] LAST_STEP = 3'(lrlm_pkg::QUO_BITS - 1);

	lrlm_pkg::back_state_t state_q, state_d;

	logic [31:0] deadline_us_q;
	logic        deadline_en_q;
	logic [15:0] interval_q;

	logic [COUNT_BITS-1:0] count_q, best_q, worst_q, recent_q;
	logic                  valid_q;
	logic [6:0]            percent_q;
	logic [31:0]           win_start_q, last_us_q;
	logic                  first_q;
	logic [31:0]           worst_delay_q, gap_min_q, gap_max_q, missed_q;

	logic [31:0] cur_us_q, cur_ms_q, gap_q, elapsed_q;
	logic        closed_q;
	logic [NUM_BITS-1:0] num_q, dvs_q;
	logic [5:0]  quo_q;
	logic [2:0]  step_q;

	logic                  out_valid_q;
	lrlm_pkg::out_item_t   out_q;

	logic                  closing;
	logic [COUNT_BITS-1:0] count_inc;
	logic [COUNT_BITS-1:0] diff;
	logic                  ge;
	logic                  out_free;

	assign closing   = (elapsed_q > {16'd0, interval_q});
	assign count_inc = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign diff      = best_q - recent_q;
	assign ge        = (num_q >= dvs_q);
	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrlm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			lrlm_pkg::S_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = q_cmd.is_clear ? lrlm_pkg::S_OUT : lrlm_pkg::S_UPD;
				end
			end
			lrlm_pkg::S_UPD: state_d = closing ? lrlm_pkg::S_MUL : lrlm_pkg::S_OUT;
			lrlm_pkg::S_MUL: state_d = lrlm_pkg::S_DIV;
			lrlm_pkg::S_DIV: begin
				if (step_q == '0) begin
					state_d = lrlm_pkg::S_OUT;
				end
			end
			lrlm_pkg::S_OUT: begin
				if (out_free) begin
					state_d = lrlm_pkg::S_IDLE;
				end
			end
			default: state_d = lrlm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_us_q <= '0;
			deadline_en_q <= 1'b0;
			interval_q    <= lrlm_pkg::INTERVAL_RESET;
		end else if (cfg.we) begin
			case (cfg.idx)
				lrlm_pkg::CFG_DEADLINE: begin
					deadline_us_q <= 32'(cfg.wdata) * lrlm_pkg::US_PER_MS;
					deadline_en_q <= (cfg.wdata != '0);
				end
				lrlm_pkg::CFG_INTERVAL: interval_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lrlm_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			best_q        <= '0;
			worst_q       <= '1;
			recent_q      <= '0;
			valid_q       <= 1'b0;
			percent_q     <= '0;
			win_start_q   <= '0;
			last_us_q     <= '0;
			first_q       <= 1'b1;
			worst_delay_q <= '0;
			gap_min_q     <= '1;
			gap_max_q     <= '0;
			missed_q      <= '0;
			closed_q      <= 1'b0;
		end else begin
			case (state_q)
				lrlm_pkg::S_IDLE: begin
					if (!q_empty && q_cmd.is_clear) begin
						count_q     <= '0;
						best_q      <= '0;
						worst_q     <= '1;
						recent_q    <= '0;
						valid_q     <= 1'b0;
						percent_q   <= '0;
						win_start_q <= q_cmd.ms;
						last_us_q   <= q_cmd.us;
						first_q     <= 1'b1;
						gap_min_q   <= '1;
						gap_max_q   <= '0;
						missed_q    <= '0;
						closed_q    <= 1'b0;
					end
				end
				lrlm_pkg::S_UPD: begin
					if (!first_q) begin
						if (gap_q > worst_delay_q) worst_delay_q <= gap_q;
						if (gap_q < gap_min_q) gap_min_q <= gap_q;
						if (gap_q > gap_max_q) gap_max_q <= gap_q;
						if (deadline_en_q && gap_q > deadline_us_q && missed_q != '1) begin
							missed_q <= missed_q + 1'b1;
						end
					end
					if (closing) begin
						recent_q    <= count_inc;
						count_q     <= '0;
						if (count_inc > best_q) best_q <= count_inc;
						if (count_inc < worst_q) worst_q <= count_inc;
						valid_q     <= 1'b1;
						win_start_q <= cur_ms_q;
					end else begin
						count_q <= count_inc;
					end
					last_us_q <= cur_us_q;
					first_q   <= 1'b0;
					closed_q  <= closing;
				end
				lrlm_pkg::S_DIV: begin
					if (step_q == '0) begin
						percent_q <= (best_q == '0) ? '0 : {quo_q, ge};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lrlm_pkg::S_IDLE: begin
				cur_us_q  <= q_cmd.us;
				cur_ms_q  <= q_cmd.ms;
				gap_q     <= q_cmd.us - last_us_q;
				elapsed_q <= q_cmd.ms - win_start_q;
			end
			lrlm_pkg::S_MUL: begin
				num_q  <= (NUM_BITS'(diff) << 6) + (NUM_BITS'(diff) << 5)
					+ (NUM_BITS'(diff) << 2);
				dvs_q  <= NUM_BITS'(best_q) << LAST_STEP;
				quo_q  <= '0;
				step_q <= LAST_STEP;
			end
			lrlm_pkg::S_DIV: begin
				if (ge) begin
					num_q <= num_q - dvs_q;
				end
				quo_q  <= {quo_q[4:0], ge};
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q - 1'b1;
			end
			lrlm_pkg::S_OUT: begin
				if (out_free) begin
					out_q.best_count       <= 32'(best_q);
					out_q.worst_count      <= 32'(worst_q);
					out_q.recent_count     <= 32'(recent_q);
					out_q.window_valid     <= valid_q;
					out_q.window_closed    <= closed_q;
					out_q.load_percent     <= percent_q;
					out_q.worst_delay_us   <= worst_delay_q;
					out_q.gap_min_us       <= gap_min_q;
					out_q.gap_max_us       <= gap_max_q;
					out_q.deadlines_missed <= missed_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		percent_q <= 7'd100)
		else $error("load percent above 100");
	a_recent_le_best: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> recent_q <= best_q)
		else $error("recent count above best count");
	a_gap_max_le_worst: assert property (@(posedge clk) disable iff (!arst_n)
		gap_max_q <= worst_delay_q)
		else $error("gap maximum above worst delay");
	a_gap_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		gap_min_q != '1 |-> gap_min_q <= gap_max_q)
		else $error("gap minimum above gap maximum");
`endif

endmodule

### design/loop_rate_load_monitor.sv
// Top level of the loop rate load monitor.
// Usage: loop events and clear commands enter through a queue-style port:
// an item transfers on a clock edge with push high and full low. Results
// leave the same way: the oldest result is on result while empty is low,
// and it transfers on an edge with pop high. Every item yields one result.
// Registers are written through cfg_we / cfg_idx / cfg_wdata with no wait;
// write them only while no item is in flight.
// From input transfer to result, a clear passes the front register, the
// queue, S_IDLE and S_OUT; an event adds S_UPD, and one that closes a
// window adds S_MUL and a restoring divide of 7 steps in S_DIV, one
// quotient bit a cycle. A new command is popped only after S_OUT.
// The front stage and a two-entry command queue keep taking items while
// the statistics engine works or a result waits to be popped; a stalled
// receiver backs up through the queue until full rises.
// Reset clears all statistics, sets the interval to 1000 ms and the
// deadline to off.
module loop_rate_load_monitor #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       push,
	output logic                                       full,
	input  lrlm_pkg::in_item_t                         item,
	output logic                                       empty,
	input  logic                                       pop,
	output lrlm_pkg::out_item_t                        result,
	input  logic                                       cfg_we,
	input  logic [lrlm_pkg::CFG_IDX_BITS-1:0]          cfg_idx,
	input  logic [lrlm_pkg::CFG_DATA_BITS-1:0]         cfg_wdata
);

	logic              cmd_valid;
	lrlm_pkg::cmd_t    cmd;
	logic              cmd_full;
	logic              q_empty;
	logic              q_pop;
	lrlm_pkg::cmd_t    q_cmd;
	lrlm_pkg::cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.idx   = cfg_idx;
	assign cfg.wdata = cfg_wdata;

	lrlm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_full  (cmd_full)
	);

	lrlm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cmd_valid),
		.wr_cmd   (cmd),
		.q_full   (cmd_full),
		.rd_pop   (q_pop),
		.q_empty  (q_empty),
		.rd_cmd   (q_cmd)
	);

	lrlm_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
